@@ rtl/ffa_pkg.sv @@
// Shared types and constants of the first-fit heap allocator.
package ffa_pkg;

   localparam int unsigned HEADER_BYTES      = 40;
   localparam int unsigned ALIGN_BYTES       = 16;
   localparam int unsigned MIN_SPLIT_PAYLOAD = 16;

   localparam int unsigned ADDR_W   = 48;
   localparam int unsigned SIZE_W   = 32;
   localparam int unsigned WANT_W   = SIZE_W + 1;
   localparam int unsigned FIT_W    = SIZE_W + 3;
   localparam int unsigned STATUS_W = 3;

   localparam logic [SIZE_W-1:0] HDR_SIZE          = SIZE_W'(HEADER_BYTES);
   localparam logic [ADDR_W-1:0] HEAP_BASE_RST     = 48'd16777216;
   localparam logic [SIZE_W-1:0] REGION_BYTES_RST  = 32'd33554432;

   localparam logic REG_HEAP_BASE    = 1'b0;
   localparam logic REG_REGION_BYTES = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_REQ  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_PTR   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NULL_FREE = 3'd4;

   // One table entry; valid marks the entries below the block count.
   typedef struct packed {
      logic              valid;
      logic              free;
      logic [SIZE_W-1:0] offset;
      logic [SIZE_W-1:0] size;
   } block_type;

   // Search key broadcast to every cell.
   typedef struct packed {
      logic              op_free;
      logic [WANT_W-1:0] want;
      logic [ADDR_W-1:0] target;
   } query_type;

   // Search outcome of one cell.
   typedef struct packed {
      logic sel;
      logic split_fit;
   } match_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_GRANT,
      CMD_GRANT_SPLIT,
      CMD_SPLIT_TAIL,
      CMD_TAKE_LEFT,
      CMD_TAKE_RIGHT,
      CMD_MARK_FREE,
      CMD_MERGE_RIGHT
   } cell_cmd_type;

endpackage

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator: a row of block cells kept in address order, with
// the control that searches, splits and merges them. Each item passes through
// accept, search, table update and response, and no new item is taken until
// the control is back in idle; a free that also merges with the block below
// passes through an extra merge step, and a stalled result port holds the
// result in the response step until the port frees up. The search is a
// priority ripple through the cells, and the table shifts by one place when
// a block is split off or merged away. Writing the region size register reloads the table.
module first_fit_heap_allocator import ffa_pkg::*; #(
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request_bytes [31:0], free_address [79:32]
   input  logic [79:0] req_tdata,
   // op (0 allocate, 1 free)
   input  logic        req_tuser,
   input  logic        req_tvalid,
   output logic        req_tready,
   // result_address [47:0], status [50:48], zeros [55:51]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [47:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_UPDATE,
      S_PREV,
      S_RESP
   } state_type;

   localparam logic [WANT_W-1:0] ALIGN_M1 = WANT_W'(ALIGN_BYTES - 1);

   state_type               state_ff;
   logic [ADDR_W-1:0]       heap_base_ff;
   logic                    op_ff;
   logic                    zero_ff;
   logic                    null_ff;
   logic [WANT_W-1:0]       want_ff;
   logic [ADDR_W-1:0]       target_ff;
   logic [MAX_BLOCKS-1:0]   sel_ff;
   logic [MAX_BLOCKS-1:0]   ge_ff;
   logic [MAX_BLOCKS-1:0]   split_ff;
   logic [ADDR_W-1:0]       res_addr_ff;
   logic [STATUS_W-1:0]     res_status_ff;
   logic                    rsp_tvalid_ff;
   logic [ADDR_W-1:0]       rsp_addr_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;

   logic [ADDR_W-1:0]       res_addr_in;
   logic [STATUS_W-1:0]     res_status_in;

   block_type               blk       [MAX_BLOCKS];
   cell_cmd_type            cmd       [MAX_BLOCKS];
   match_type               match_v   [MAX_BLOCKS];
   logic [MAX_BLOCKS:0]     found;
   logic [MAX_BLOCKS-1:0]   sel_vec;
   logic [MAX_BLOCKS-1:0]   split_vec;
   logic [MAX_BLOCKS-1:0]   valid_v;
   logic [MAX_BLOCKS-1:0]   free_v;
   logic [MAX_BLOCKS-1:0]   sel_up;
   logic [MAX_BLOCKS-1:0]   ge_up;
   logic [MAX_BLOCKS-1:0]   sel_dn;
   logic [MAX_BLOCKS-1:0]   valid_dn;
   logic [MAX_BLOCKS-1:0]   free_dn;

   query_type               query;
   block_type               first_blk;
   logic [SIZE_W-1:0]       init_src;
   logic                    csr_init;
   logic                    go;
   logic                    split_go;
   logic                    merge_next;
   logic                    merge_prev;
   logic                    slot_free;
   logic [SIZE_W-1:0]       sel_off;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_addr_ff};
   assign slot_free  = !rsp_tvalid_ff || rsp_tready;

   assign csr_init  = csr_valid && csr_ready && (csr_index == REG_REGION_BYTES);
   assign init_src  = reset ? REGION_BYTES_RST : csr_wdata[SIZE_W-1:0];
   assign first_blk = '{valid: 1'b1, free: 1'b1, offset: '0,
                        size: (init_src >= HDR_SIZE) ? init_src - HDR_SIZE : '0};

   assign query = '{op_free: op_ff, want: want_ff, target: target_ff};

   assign found[0] = 1'b0;

   genvar k;
   generate
      for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
         block_type left_blk;
         block_type right_blk;
         block_type init_blk;

         if (k == 0) begin : g_first
            assign left_blk = '0;
            assign init_blk = first_blk;
         end else begin : g_rest
            assign left_blk = blk[k-1];
            assign init_blk = '0;
         end

         if (k == MAX_BLOCKS - 1) begin : g_last
            assign right_blk = '0;
         end else begin : g_inner
            assign right_blk = blk[k+1];
         end

         assign sel_vec[k]   = match_v[k].sel;
         assign split_vec[k] = match_v[k].split_fit;
         assign valid_v[k]   = blk[k].valid;
         assign free_v[k]    = blk[k].free;

         // Per-cell command: a split opens a gap above the granted block, a
         // merge closes the gap left by the absorbed block.
         always_comb begin
            cmd[k] = CMD_HOLD;
            if (state_ff == S_UPDATE && go) begin
               if (!op_ff) begin
                  if (sel_ff[k]) begin
                     cmd[k] = split_go ? CMD_GRANT_SPLIT : CMD_GRANT;
                  end else if (split_go && sel_up[k]) begin
                     cmd[k] = CMD_SPLIT_TAIL;
                  end else if (split_go && ge_up[k]) begin
                     cmd[k] = CMD_TAKE_LEFT;
                  end else begin
                     cmd[k] = CMD_HOLD;
                  end
               end else begin
                  if (sel_ff[k]) begin
                     cmd[k] = merge_next ? CMD_MERGE_RIGHT : CMD_MARK_FREE;
                  end else if (merge_next && ge_ff[k]) begin
                     cmd[k] = CMD_TAKE_RIGHT;
                  end else begin
                     cmd[k] = CMD_HOLD;
                  end
               end
            end else if (state_ff == S_PREV) begin
               if (sel_dn[k]) begin
                  cmd[k] = CMD_MERGE_RIGHT;
               end else if (ge_ff[k]) begin
                  cmd[k] = CMD_TAKE_RIGHT;
               end else begin
                  cmd[k] = CMD_HOLD;
               end
            end
         end

         ffa_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .init      (csr_init),
            .init_blk  (init_blk),
            .cmd       (cmd[k]),
            .query     (query),
            .left_blk  (left_blk),
            .right_blk (right_blk),
            .found_in  (found[k]),
            .blk       (blk[k]),
            .match_out (match_v[k]),
            .found_out (found[k+1])
         );
      end
   endgenerate

   // Neighbor views of the registered search result and the table bits.
   assign sel_up   = {sel_ff[MAX_BLOCKS-2:0], 1'b0};
   assign ge_up    = {ge_ff[MAX_BLOCKS-2:0], 1'b0};
   assign sel_dn   = {1'b0, sel_ff[MAX_BLOCKS-1:1]};
   assign valid_dn = {1'b0, valid_v[MAX_BLOCKS-1:1]};
   assign free_dn  = {1'b0, free_v[MAX_BLOCKS-1:1]};

   assign go         = ge_ff[MAX_BLOCKS-1] && !(op_ff ? null_ff : zero_ff);
   assign split_go   = (|(sel_ff & split_ff)) && !valid_v[MAX_BLOCKS-1];
   assign merge_next = |(sel_ff & valid_dn & free_dn);
   assign merge_prev = |(sel_dn & free_v);

   always_comb begin
      sel_off = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         sel_off = sel_off | (sel_ff[i] ? blk[i].offset : '0);
      end
   end

   always_comb begin
      res_addr_in = '0;
      if (op_ff) begin
         if (null_ff) begin
            res_status_in = ST_NULL_FREE;
         end else if (!ge_ff[MAX_BLOCKS-1]) begin
            res_status_in = ST_BAD_PTR;
         end else begin
            res_status_in = ST_OK;
         end
      end else begin
         if (zero_ff) begin
            res_status_in = ST_ZERO_REQ;
         end else if (!ge_ff[MAX_BLOCKS-1]) begin
            res_status_in = ST_NO_MEMORY;
         end else begin
            res_status_in = ST_OK;
            res_addr_in   = heap_base_ff + ADDR_W'(sel_off) + ADDR_W'(HEADER_BYTES);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         heap_base_ff  <= HEAP_BASE_RST;
      end else begin
         if (csr_valid && csr_ready && csr_index == REG_HEAP_BASE) begin
            heap_base_ff <= csr_wdata;
         end
         // In the response state the valid flag is set below whenever the
         // slot frees up, so it is only cleared here in the other states.
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_RESP) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff     <= req_tuser;
                  zero_ff   <= (req_tdata[31:0] == '0);
                  null_ff   <= (req_tdata[79:32] == '0);
                  want_ff   <= (WANT_W'(req_tdata[31:0]) + ALIGN_M1) & ~ALIGN_M1;
                  target_ff <= req_tdata[79:32] - heap_base_ff - ADDR_W'(HEADER_BYTES);
                  state_ff  <= S_MATCH;
               end
            end
            S_MATCH: begin
               sel_ff   <= sel_vec;
               ge_ff    <= found[MAX_BLOCKS:1];
               split_ff <= split_vec;
               state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               res_addr_ff   <= res_addr_in;
               res_status_ff <= res_status_in;
               state_ff      <= (op_ff && go && merge_prev) ? S_PREV : S_RESP;
            end
            S_PREV: begin
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (slot_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/ffa_cell.sv @@
// One table cell: holds one heap block, searches it and shifts with its neighbors.
module ffa_cell import ffa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         init,
   input  block_type    init_blk,
   input  cell_cmd_type cmd,
   input  query_type    query,
   input  block_type    left_blk,
   input  block_type    right_blk,
   input  logic         found_in,
   output block_type    blk,
   output match_type    match_out,
   output logic         found_out
);

   block_type blk_ff;
   block_type blk_in;
   logic      hit;

   // A free item matches on the header offset, since the target already has
   // the heap base and the header taken off.
   always_comb begin
      if (query.op_free) begin
         hit = blk_ff.valid && (ADDR_W'(blk_ff.offset) == query.target);
      end else begin
         hit = blk_ff.valid && blk_ff.free && (WANT_W'(blk_ff.size) >= query.want);
      end
   end

   assign match_out.sel       = hit & ~found_in;
   assign match_out.split_fit = FIT_W'(blk_ff.size) >=
                                FIT_W'(query.want) + FIT_W'(HEADER_BYTES + MIN_SPLIT_PAYLOAD);
   assign found_out           = found_in | hit;
   assign blk                 = blk_ff;

   always_comb begin
      blk_in = blk_ff;
      unique case (cmd)
         CMD_HOLD: begin
            blk_in = blk_ff;
         end
         CMD_GRANT: begin
            blk_in.free = 1'b0;
         end
         CMD_GRANT_SPLIT: begin
            blk_in.free = 1'b0;
            blk_in.size = query.want[SIZE_W-1:0];
         end
         CMD_SPLIT_TAIL: begin
            blk_in.valid  = 1'b1;
            blk_in.free   = 1'b1;
            blk_in.offset = left_blk.offset + HDR_SIZE + query.want[SIZE_W-1:0];
            blk_in.size   = left_blk.size - query.want[SIZE_W-1:0] - HDR_SIZE;
         end
         CMD_TAKE_LEFT: begin
            blk_in = left_blk;
         end
         CMD_TAKE_RIGHT: begin
            blk_in = right_blk;
         end
         CMD_MARK_FREE: begin
            blk_in.free = 1'b1;
         end
         CMD_MERGE_RIGHT: begin
            blk_in.free = 1'b1;
            blk_in.size = blk_ff.size + HDR_SIZE + right_blk.size;
         end
         default: begin
            blk_in = blk_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || init) begin
         blk_ff <= init_blk;
      end else begin
         blk_ff <= blk_in;
      end
   end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the first-fit heap allocator with a built-in predictor.
module tb_top;
   import ffa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BLOCKS  = 64;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 400;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic              op;
      logic [SIZE_W-1:0] request_bytes;
      logic [ADDR_W-1:0] free_address;
   } heap_op_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   address;
      logic [STATUS_W-1:0] status;
   } reply_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic [79:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [47:0] csr_wdata  = '0;

   // Predicted heap table and register copies.
   logic [ADDR_W-1:0] cfg_base;
   logic [SIZE_W-1:0] cfg_size;
   logic [SIZE_W-1:0] tbl_offset [MAX_BLOCKS];
   logic [SIZE_W-1:0] tbl_size   [MAX_BLOCKS];
   logic              tbl_free   [MAX_BLOCKS];
   int                tbl_count;

   heap_op_type request_backlog [$];
   reply_type   awaited_replies [$];

   int fail_count   = 0;
   int quiet_cycles = 0;
   int req_gap      = 0;
   int rsp_gap      = 0;
   int hold_left    = 0;
   bit hold_request = 1'b0;
   bit steady       = 1'b0;
   bit req_fired    = 1'b0;

   first_fit_heap_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void table_reload();
      for (int k = 0; k < MAX_BLOCKS; k++) begin
         tbl_offset[k] = '0;
         tbl_size[k]   = '0;
         tbl_free[k]   = 1'b0;
      end
      tbl_size[0]  = (cfg_size >= HDR_SIZE) ? cfg_size - HDR_SIZE : '0;
      tbl_free[0]  = 1'b1;
      tbl_count    = 1;
   endfunction

   function automatic logic [ADDR_W-1:0] payload_address(int i);
      return cfg_base + ADDR_W'(tbl_offset[i]) + ADDR_W'(HEADER_BYTES);
   endfunction

   function automatic void drop_entry(int i);
      for (int k = i; k + 1 < tbl_count; k++) begin
         tbl_offset[k] = tbl_offset[k + 1];
         tbl_size[k]   = tbl_size[k + 1];
         tbl_free[k]   = tbl_free[k + 1];
      end
      if (tbl_count > 1) tbl_count--;
   endfunction

   // First fit over the address-ordered table, splitting off the tail when it
   // can hold a header and a minimum payload and the table has room.
   function automatic reply_type place_request(logic [SIZE_W-1:0] req);
      reply_type   r;
      logic [63:0] want;
      logic [63:0] sz;
      r = '0;
      if (req == '0) begin
         r.status = ST_ZERO_REQ;
         return r;
      end
      want = ((64'(req) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
      for (int i = 0; i < tbl_count; i++) begin
         sz = 64'(tbl_size[i]);
         if (tbl_free[i] && sz >= want) begin
            if (sz >= want + HEADER_BYTES + MIN_SPLIT_PAYLOAD && tbl_count < MAX_BLOCKS) begin
               for (int k = tbl_count; k > i + 1; k--) begin
                  tbl_offset[k] = tbl_offset[k - 1];
                  tbl_size[k]   = tbl_size[k - 1];
                  tbl_free[k]   = tbl_free[k - 1];
               end
               tbl_offset[i + 1] = SIZE_W'(64'(tbl_offset[i]) + HEADER_BYTES + want);
               tbl_size[i + 1]   = SIZE_W'(sz - want - HEADER_BYTES);
               tbl_free[i + 1]   = 1'b1;
               tbl_size[i]       = SIZE_W'(want);
               tbl_count++;
            end
            tbl_free[i] = 1'b0;
            r.address   = payload_address(i);
            r.status    = ST_OK;
            return r;
         end
      end
      r.status = ST_NO_MEMORY;
      return r;
   endfunction

   // Releases a block and merges it with a free successor, then a free predecessor.
   function automatic reply_type release_address(logic [ADDR_W-1:0] addr);
      reply_type r;
      int        i;
      r = '0;
      if (addr == '0) begin
         r.status = ST_NULL_FREE;
         return r;
      end
      for (i = 0; i < tbl_count; i++)
         if (payload_address(i) == addr) break;
      if (i >= tbl_count) begin
         r.status = ST_BAD_PTR;
         return r;
      end
      tbl_free[i] = 1'b1;
      if (i + 1 < tbl_count && tbl_free[i + 1]) begin
         tbl_size[i] = tbl_size[i] + HDR_SIZE + tbl_size[i + 1];
         drop_entry(i + 1);
      end
      if (i > 0 && tbl_free[i - 1]) begin
         tbl_size[i - 1] = tbl_size[i - 1] + HDR_SIZE + tbl_size[i];
         drop_entry(i);
      end
      r.status = ST_OK;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (steady || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Mostly requests that land on real blocks, with some noise mixed in.
   function automatic heap_op_type pick_item(int alloc_pct, int max_req);
      heap_op_type       it;
      int                r;
      logic [ADDR_W-1:0] a;
      it = '0;
      r  = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct) begin
         it.op           = OP_ALLOC;
         it.free_address = ADDR_W'({$urandom, $urandom});
         if (r < 80) it.request_bytes = $urandom_range(1, max_req);
         else if (r < 88) it.request_bytes = '0;
         else if (r < 95) it.request_bytes = $urandom;
         else it.request_bytes = tbl_size[$urandom_range(tbl_count - 1)];
      end else begin
         it.op            = OP_FREE;
         it.request_bytes = $urandom;
         a = payload_address($urandom_range(tbl_count - 1));
         if (r < 75) it.free_address = a;
         else if (r < 83) it.free_address = '0;
         else if (r < 93) it.free_address = ADDR_W'({$urandom, $urandom});
         else it.free_address = ($urandom_range(1) == 1) ? a + 48'd16 : a - 48'd8;
      end
      return it;
   endfunction

   // Request driver.
   always @(negedge clock) begin
      heap_op_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            next_item = request_backlog.pop_front();
            req_tdata  <= {next_item.free_address, next_item.request_bytes};
            req_tuser  <= next_item.op;
            req_tvalid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response sink, with one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = pick_gap();
      end
   end

   // Monitor: predicts on each accepted item and checks each accepted result.
   always @(posedge clock) begin
      reply_type got;
      reply_type due;
      req_fired = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            if (req_tuser == OP_ALLOC)
               awaited_replies.push_back(place_request(req_tdata[31:0]));
            else
               awaited_replies.push_back(release_address(req_tdata[79:32]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.address = rsp_tdata[47:0];
            got.status  = rsp_tdata[50:48];
            if (awaited_replies.size() == 0) begin
               $error("result item with no request outstanding: address %h status %0d",
                      got.address, got.status);
               fail_count++;
            end else begin
               due = awaited_replies.pop_front();
               if (got.address !== due.address) begin
                  $error("result_address: expected %h, got %h", due.address, got.address);
                  fail_count++;
               end
               if (got.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, got.status);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_HEAP_BASE) begin
               cfg_base = csr_wdata;
            end else begin
               cfg_size = csr_wdata[31:0];
               table_reload();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAIL first_fit_heap_allocator");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic settle();
      while (request_backlog.size() != 0 || req_tvalid || awaited_replies.size() != 0)
         @(posedge clock);
   endtask

   task automatic queue_item(logic op, logic [SIZE_W-1:0] req, logic [ADDR_W-1:0] addr);
      request_backlog.push_back('{op: op, request_bytes: req, free_address: addr});
   endtask

   task automatic write_reg(logic idx, logic [47:0] data);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Upper bits of a region size write carry junk that the block must drop.
   task automatic setup_heap(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] size);
      write_reg(REG_HEAP_BASE, base);
      write_reg(REG_REGION_BYTES, {16'($urandom), size});
   endtask

   task automatic run_phase(int n, int alloc_pct, int max_req);
      repeat (n) begin
         while (request_backlog.size() >= 2) @(negedge clock);
         request_backlog.push_back(pick_item(alloc_pct, max_req));
      end
   endtask

   initial begin
      logic [SIZE_W-1:0] sz;
      cfg_base = HEAP_BASE_RST;
      cfg_size = REGION_BYTES_RST;
      table_reload();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero request, rounding, a request that cannot fit, null and unknown frees.
      queue_item(OP_ALLOC, 32'd0, '0);
      queue_item(OP_ALLOC, 32'd1, '0);
      queue_item(OP_ALLOC, 32'd16, '0);
      queue_item(OP_ALLOC, 32'd17, '0);
      queue_item(OP_ALLOC, '1, '0);
      queue_item(OP_FREE, '1, '0);
      queue_item(OP_FREE, '0, '1);
      settle();
      // Exact fit of the tail block, after which nothing is left.
      queue_item(OP_ALLOC, tbl_size[tbl_count - 1], '0);
      queue_item(OP_ALLOC, 32'd1, '0);
      settle();
      queue_item(OP_FREE, '0, payload_address(1) + 48'd1);
      queue_item(OP_FREE, '0, payload_address(1));
      queue_item(OP_FREE, '0, payload_address(1));
      queue_item(OP_FREE, '0, payload_address(0));
      settle();
      queue_item(OP_FREE, '0, payload_address(1));
      settle();
      queue_item(OP_FREE, '0, payload_address(1));
      settle();
      // Remainder too small to split, then a remainder exactly large enough.
      sz = tbl_size[0];
      queue_item(OP_ALLOC, sz - 32'd48, '0);
      queue_item(OP_ALLOC, 32'd1, '0);
      settle();
      queue_item(OP_FREE, '0, payload_address(0));
      settle();
      queue_item(OP_ALLOC, tbl_size[0] - 32'd56, '0);
      queue_item(OP_ALLOC, 32'd16, '0);
      queue_item(OP_ALLOC, 32'd1, '0);

      setup_heap('0, 32'd256);
      run_phase(100, 55, 120);

      // The sink stalls for a long stretch while requests keep coming.
      setup_heap(48'hFFFF_FFFF_FF00, 32'hFFFF_FFFF);
      hold_request = 1'b1;
      run_phase(150, 65, 1 << 20);

      // A heap smaller than one header leaves no payload at all.
      write_reg(REG_REGION_BYTES, 48'd30);
      run_phase(15, 60, 64);

      // Small requests in a small heap fill the table.
      steady = 1'b1;
      setup_heap(ADDR_W'({$urandom, $urandom}), $urandom_range(8192, 16384));
      run_phase(200, 80, 64);
      steady = 1'b0;

      setup_heap(48'hFFFF_FFFF_FFFF, 32'd33554432);
      run_phase(150, 60, 4096);

      // Moving the base keeps the table; old addresses become unknown.
      write_reg(REG_HEAP_BASE, HEAP_BASE_RST);
      run_phase(100, 50, 4096);

      settle();
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS first_fit_heap_allocator");
      end else begin
         $display("FAIL first_fit_heap_allocator");
      end
      $finish;
   end

endmodule
